// File: hdl/scsa_pkg.sv
package scsa_pkg;

  // Pool dimensions.
  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned MAX_SLOTS   = 64;

  // Number of class register sets held by the configuration port.
  localparam int unsigned CFG_CLASSES = 4;

  // Field widths.
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [CLS_W-1:0]  cls_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  // Request kinds.
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  // Register map, word index.
  typedef enum logic [2:0] {
    REG_SIZE_0  = 3'd0,
    REG_SIZE_1  = 3'd1,
    REG_SIZE_2  = 3'd2,
    REG_SIZE_3  = 3'd3,
    REG_COUNT_0 = 3'd4,
    REG_COUNT_1 = 3'd5,
    REG_COUNT_2 = 3'd6,
    REG_COUNT_3 = 3'd7
  } reg_idx_e;

endpackage

// File: hdl/size_class_slot_allocator_unit.sv
// Size-class slot allocator. Each item is an allocate or a free request and
// gives exactly one result item carrying a status, the granted slot id and
// the total free count. A new item is taken every cycle while the result
// channel does not stall; each item sits in the input register, where the
// class search, the stack pointer update and the single free-stack memory
// access are done, and then in the output register, so the sustained rate is
// one item per cycle when nothing stalls.
// Any configuration write, like reset, rebuilds the pool at once: per-entry
// valid bits stand in for the initial ascending stack contents, so there is no
// clearing pass and an item may follow in the very next cycle.
module size_class_slot_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic [scsa_pkg::SIZE_W-1:0]  request_size_i,
  input  logic [scsa_pkg::SLOT_W-1:0]  slot_to_free_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [scsa_pkg::SLOT_W-1:0]  granted_slot_o,
  output logic [scsa_pkg::CNT_W-1:0]   free_slots_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [scsa_pkg::DATA_W-1:0]  pwdata,
  output logic [scsa_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  // Configuration registers and derived class layout.
  scsa_pkg::size_t size_q  [scsa_pkg::CFG_CLASSES];
  scsa_pkg::size_t size_d  [scsa_pkg::CFG_CLASSES];
  scsa_pkg::cnt_t  count_q [scsa_pkg::CFG_CLASSES];
  scsa_pkg::cnt_t  count_d [scsa_pkg::CFG_CLASSES];
  scsa_pkg::cnt_t  base_q  [scsa_pkg::NUM_CLASSES];
  scsa_pkg::cnt_t  base_d  [scsa_pkg::NUM_CLASSES];
  scsa_pkg::cnt_t  len_q   [scsa_pkg::NUM_CLASSES];
  scsa_pkg::cnt_t  len_d   [scsa_pkg::NUM_CLASSES];
  scsa_pkg::cnt_t  total_q;
  scsa_pkg::cnt_t  total_d;

  logic               cfg_we;
  scsa_pkg::reg_idx_e cfg_idx;

  // Allocator state.
  scsa_pkg::cnt_t               top_q [scsa_pkg::NUM_CLASSES];
  scsa_pkg::cnt_t               free_total_q;
  scsa_pkg::cnt_t               free_total_d;
  scsa_pkg::slot_t              mem_q [scsa_pkg::MAX_SLOTS];
  logic [scsa_pkg::MAX_SLOTS-1:0] valid_q;
  logic [scsa_pkg::MAX_SLOTS-1:0] flags_q;
  logic [scsa_pkg::MAX_SLOTS-1:0] flags_d;
  logic                         pend_q;

  // Input register.
  logic            a_valid_q;
  logic            a_type_q;
  scsa_pkg::size_t a_size_q;
  scsa_pkg::slot_t a_id_q;

  // Output register.
  logic              b_valid_q;
  scsa_pkg::status_e b_status_q;
  scsa_pkg::cnt_t    b_free_q;
  scsa_pkg::slot_t   rd_q;

  // Request evaluation.
  logic              advance;
  logic              in_accept;
  logic              fits_any;
  logic              pop_found;
  scsa_pkg::cls_t    pop_cls;
  scsa_pkg::cnt_t    pop_top;
  scsa_pkg::slot_t   pop_addr;
  logic              free_ok;
  logic              flag_eff;
  scsa_pkg::cls_t    free_cls;
  logic              push_ok;
  scsa_pkg::slot_t   push_addr;
  logic              do_pop;
  logic              do_push;
  logic              do_free;
  scsa_pkg::status_e status_d;

  // Configuration port decode; pready is tied high.
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = scsa_pkg::reg_idx_e'(paddr[4:2]);

  always_comb begin
    size_d  = size_q;
    count_d = count_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        scsa_pkg::REG_SIZE_0:  size_d[0]  = pwdata;
        scsa_pkg::REG_SIZE_1:  size_d[1]  = pwdata;
        scsa_pkg::REG_SIZE_2:  size_d[2]  = pwdata;
        scsa_pkg::REG_SIZE_3:  size_d[3]  = pwdata;
        scsa_pkg::REG_COUNT_0: count_d[0] = pwdata[scsa_pkg::CNT_W-1:0];
        scsa_pkg::REG_COUNT_1: count_d[1] = pwdata[scsa_pkg::CNT_W-1:0];
        scsa_pkg::REG_COUNT_2: count_d[2] = pwdata[scsa_pkg::CNT_W-1:0];
        scsa_pkg::REG_COUNT_3: count_d[3] = pwdata[scsa_pkg::CNT_W-1:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      scsa_pkg::REG_SIZE_0:  prdata = size_q[0];
      scsa_pkg::REG_SIZE_1:  prdata = size_q[1];
      scsa_pkg::REG_SIZE_2:  prdata = size_q[2];
      scsa_pkg::REG_SIZE_3:  prdata = size_q[3];
      scsa_pkg::REG_COUNT_0: prdata = {{(scsa_pkg::DATA_W-scsa_pkg::CNT_W){1'b0}}, count_q[0]};
      scsa_pkg::REG_COUNT_1: prdata = {{(scsa_pkg::DATA_W-scsa_pkg::CNT_W){1'b0}}, count_q[1]};
      scsa_pkg::REG_COUNT_2: prdata = {{(scsa_pkg::DATA_W-scsa_pkg::CNT_W){1'b0}}, count_q[2]};
      scsa_pkg::REG_COUNT_3: prdata = {{(scsa_pkg::DATA_W-scsa_pkg::CNT_W){1'b0}}, count_q[3]};
    endcase
  end

  // Class layout from the new counts, clipped so the pool never exceeds its size.
  always_comb begin
    scsa_pkg::cnt_t acc;
    scsa_pkg::cnt_t room;
    acc = '0;
    for (int c = 0; c < int'(scsa_pkg::NUM_CLASSES); c++) begin
      room      = scsa_pkg::CNT_W'(scsa_pkg::MAX_SLOTS) - acc;
      base_d[c] = acc;
      len_d[c]  = (count_d[c] > room) ? room : count_d[c];
      acc       = acc + len_d[c];
    end
    total_d = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < int'(scsa_pkg::CFG_CLASSES); c++) begin
        size_q[c]  <= '0;
        count_q[c] <= '0;
      end
      for (int c = 0; c < int'(scsa_pkg::NUM_CLASSES); c++) begin
        base_q[c] <= '0;
        len_q[c]  <= '0;
      end
      total_q <= '0;
    end else if (cfg_we) begin
      size_q  <= size_d;
      count_q <= count_d;
      base_q  <= base_d;
      len_q   <= len_d;
      total_q <= total_d;
    end
  end

  // Handshake: the input register moves on whenever the output register is free.
  assign advance    = a_valid_q & (~b_valid_q | ~out_stall_i);
  assign in_stall_o = a_valid_q & ~advance;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_accept) begin
      a_valid_q <= 1'b1;
    end else if (advance) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_type_q <= req_type_i;
      a_size_q <= request_size_i;
      a_id_q   <= slot_to_free_i;
    end
  end

  // Allocate: first fitting class, then the first non-empty class from there on.
  always_comb begin
    logic seen;
    seen      = 1'b0;
    pop_found = 1'b0;
    pop_cls   = '0;
    for (int c = 0; c < int'(scsa_pkg::NUM_CLASSES); c++) begin
      if (size_q[c] >= a_size_q) begin
        seen = 1'b1;
      end
      if (seen && (top_q[c] != '0) && !pop_found) begin
        pop_found = 1'b1;
        pop_cls   = scsa_pkg::CLS_W'(c);
      end
    end
    fits_any = seen;
  end

  assign pop_top  = top_q[pop_cls] - scsa_pkg::CNT_W'(1);
  assign pop_addr = scsa_pkg::SLOT_W'(base_q[pop_cls] + pop_top);

  // Free: range and allocated-mark check, with the mark of the grant still in
  // flight forwarded from the output register.
  assign flag_eff = flags_q[a_id_q] | (pend_q & (rd_q == a_id_q));
  assign free_ok  = ({1'b0, a_id_q} < total_q) & flag_eff;

  always_comb begin
    free_cls = '0;
    for (int c = int'(scsa_pkg::NUM_CLASSES) - 1; c >= 0; c--) begin
      if (({1'b0, a_id_q} >= base_q[c]) && ({1'b0, a_id_q} < base_q[c] + len_q[c])) begin
        free_cls = scsa_pkg::CLS_W'(c);
      end
    end
  end

  assign push_ok   = top_q[free_cls] < len_q[free_cls];
  assign push_addr = scsa_pkg::SLOT_W'(base_q[free_cls] + top_q[free_cls]);

  assign do_pop  = advance & (a_type_q == scsa_pkg::REQ_ALLOC) & fits_any & pop_found;
  assign do_free = advance & (a_type_q == scsa_pkg::REQ_FREE) & free_ok;
  assign do_push = do_free & push_ok;

  // Status and free count of the result.
  always_comb begin
    free_total_d = free_total_q;
    if (a_type_q == scsa_pkg::REQ_ALLOC) begin
      if (!fits_any) begin
        status_d = scsa_pkg::ST_TOO_LARGE;
      end else if (!pop_found) begin
        status_d = scsa_pkg::ST_NO_FREE;
      end else begin
        status_d = scsa_pkg::ST_OK;
        if (free_total_q != '0) begin
          free_total_d = free_total_q - scsa_pkg::CNT_W'(1);
        end
      end
    end else begin
      if (!free_ok) begin
        status_d = scsa_pkg::ST_INVALID;
      end else begin
        status_d = scsa_pkg::ST_OK;
        if (push_ok) begin
          free_total_d = free_total_q + scsa_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Stack pointers and free count; a configuration write rebuilds them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < int'(scsa_pkg::NUM_CLASSES); c++) begin
        top_q[c] <= '0;
      end
      free_total_q <= '0;
    end else if (cfg_we) begin
      top_q        <= len_d;
      free_total_q <= total_d;
    end else if (advance) begin
      if (do_pop) begin
        top_q[pop_cls] <= pop_top;
      end
      if (do_push) begin
        top_q[free_cls] <= top_q[free_cls] + scsa_pkg::CNT_W'(1);
      end
      free_total_q <= free_total_d;
    end
  end

  // Entry valid bits: an entry never pushed to holds its own index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cfg_we) begin
      valid_q <= '0;
    end else if (do_push) begin
      valid_q[push_addr] <= 1'b1;
    end
  end

  // Free-stack memory with registered read; the read register is the granted id.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[push_addr] <= a_id_q;
    end
    if (advance) begin
      if (do_pop) begin
        rd_q <= valid_q[pop_addr] ? mem_q[pop_addr] : pop_addr;
      end else begin
        rd_q <= '0;
      end
    end
  end

  // Allocated marks; a grant is marked through the pend_q register, a free clears
  // at once and wins over a grant mark of the same id.
  always_comb begin
    flags_d = flags_q;
    if (pend_q) begin
      flags_d[rd_q] = 1'b1;
    end
    if (do_free) begin
      flags_d[a_id_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      pend_q  <= 1'b0;
    end else if (cfg_we) begin
      flags_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      flags_q <= flags_d;
      pend_q  <= do_pop;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_status_q <= status_d;
      b_free_q   <= free_total_d;
    end
  end

  assign out_valid_o    = b_valid_q;
  assign status_o       = b_status_q;
  assign granted_slot_o = rd_q;
  assign free_slots_o   = b_free_q;

endmodule

// File: hdl/scsa_checker.sv
module scsa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [1:0]                   status_o,
  input logic [scsa_pkg::SLOT_W-1:0]  granted_slot_o,
  input logic [scsa_pkg::CNT_W-1:0]   free_slots_o
);

  // A stalled result item stays on the port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_slot_o) && $stable(free_slots_o))
    else $error("stalled result item changed");

  // Only a successful allocate hands out a non-zero slot id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != scsa_pkg::ST_OK) |-> granted_slot_o == '0)
    else $error("slot id given on a failed request");

  // The free count never exceeds the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_slots_o <= scsa_pkg::CNT_W'(scsa_pkg::MAX_SLOTS))
    else $error("free count beyond pool size");

  // The request side stalls only while a result item is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a blocked result item");

endmodule

bind size_class_slot_allocator_unit scsa_checker u_scsa_checker (.*);
